FILE: rtl/dtpm_pkg.sv
// Shared constants and types for the DMX-to-level piecewise map.
package dtpm_pkg;

  // Input and segment geometry
  localparam int DMX_WIDTH      = 8;
  localparam int SEG_WIDTH      = 4;
  localparam int DIVISOR_WIDTH  = 8;
  localparam logic [DIVISOR_WIDTH-1:0] SEG_SPAN = 8'd16;

  // Configuration port geometry
  localparam int CFG_ADDR_WIDTH = 4;
  localparam int APB_DATA_WIDTH = 32;

  // Register reset values
  localparam logic [SEG_WIDTH-1:0] SLOW_SEGMENT_RESET = 4'd6;
  localparam int LEVEL_BEFORE_RESET = 615;
  localparam int LEVEL_AT_RESET     = 735;
  localparam int LEVEL_TOP_RESET    = 897;

  // Register map, by word index
  typedef enum logic [1:0] {
    REG_SLOW_SEGMENT = 2'd0,
    REG_LEVEL_BEFORE = 2'd1,
    REG_LEVEL_AT     = 2'd2,
    REG_LEVEL_TOP    = 2'd3
  } cfg_reg_e;

endpackage

FILE: rtl/dmx_to_pwm_piecewise_map_unit.sv
// Top level of the DMX-to-level piecewise linear map.
// Pipeline: a taken request passes these registered stages in order before its result strobes:
//   operand select, multiply, one divider stage per quotient bit, then add and saturate.
// Throughput: one request per cycle; busy stays low and results are never held back.
// Reset: asynchronous, active low; clears all valid bits and loads the register defaults.
module dmx_to_pwm_piecewise_map_unit #(
  parameter int LEVEL_WIDTH = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [dtpm_pkg::DMX_WIDTH-1:0]       dmx_value_i,
  output logic                                 done_o,
  output logic [LEVEL_WIDTH-1:0]               mapped_level_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dtpm_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [dtpm_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [dtpm_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                 pready
);
  import dtpm_pkg::*;

  localparam int NUM_WIDTH = LEVEL_WIDTH + DMX_WIDTH;
  localparam int LATENCY   = LEVEL_WIDTH + 3;

  logic [SEG_WIDTH-1:0]     slow_segment;
  logic [LEVEL_WIDTH-1:0]   level_before;
  logic [LEVEL_WIDTH-1:0]   level_at;
  logic [LEVEL_WIDTH-1:0]   level_top;

  logic                     prod_valid;
  logic [NUM_WIDTH-1:0]     product;
  logic [DIVISOR_WIDTH-1:0] divisor;
  logic [LEVEL_WIDTH-1:0]   prod_base;

  logic                     quo_valid;
  logic [LEVEL_WIDTH-1:0]   quotient;
  logic [LEVEL_WIDTH-1:0]   quo_base;

  logic [LEVEL_WIDTH:0]     sum;
  logic [LEVEL_WIDTH-1:0]   level_d, level_q;
  logic                     done_q;
  logic                     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dtpm_cfg #(.LEVEL_WIDTH(LEVEL_WIDTH)) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .slow_segment_o (slow_segment),
    .level_before_o (level_before),
    .level_at_o     (level_at),
    .level_top_o    (level_top)
  );

  dtpm_front #(.LEVEL_WIDTH(LEVEL_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (accept),
    .dmx_value_i    (dmx_value_i),
    .slow_segment_i (slow_segment),
    .level_before_i (level_before),
    .level_at_i     (level_at),
    .level_top_i    (level_top),
    .valid_o        (prod_valid),
    .product_o      (product),
    .divisor_o      (divisor),
    .base_o         (prod_base)
  );

  dtpm_div #(.LEVEL_WIDTH(LEVEL_WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (prod_valid),
    .numer_i    (product),
    .divisor_i  (divisor),
    .base_i     (prod_base),
    .valid_o    (quo_valid),
    .quotient_o (quotient),
    .base_o     (quo_base)
  );

  // Add the piece start and saturate at full scale
  assign sum     = {1'b0, quo_base} + {1'b0, quotient};
  assign level_d = sum[LEVEL_WIDTH] ? '1 : sum[LEVEL_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= quo_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign done_o         = done_q;
  assign mapped_level_o = level_q;

  // Every result strobe traces back to a request that was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without a matching request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    quo_valid |-> $past(prod_valid, LEVEL_WIDTH))
    else $error("divider valid out of step with its input");

endmodule

FILE: rtl/dtpm_cfg.sv
// APB register file holding the curve shape.
module dtpm_cfg #(
  parameter int LEVEL_WIDTH = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dtpm_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [dtpm_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [dtpm_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                 pready,
  output logic [dtpm_pkg::SEG_WIDTH-1:0]       slow_segment_o,
  output logic [LEVEL_WIDTH-1:0]               level_before_o,
  output logic [LEVEL_WIDTH-1:0]               level_at_o,
  output logic [LEVEL_WIDTH-1:0]               level_top_o
);
  import dtpm_pkg::*;

  logic [SEG_WIDTH-1:0]   slow_segment_q;
  logic [LEVEL_WIDTH-1:0] level_before_q;
  logic [LEVEL_WIDTH-1:0] level_at_q;
  logic [LEVEL_WIDTH-1:0] level_top_q;
  logic                   wr_en;
  cfg_reg_e               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = cfg_reg_e'(paddr[3:2]);

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_segment_q <= SLOW_SEGMENT_RESET;
      level_before_q <= LEVEL_WIDTH'(LEVEL_BEFORE_RESET);
      level_at_q     <= LEVEL_WIDTH'(LEVEL_AT_RESET);
      level_top_q    <= LEVEL_WIDTH'(LEVEL_TOP_RESET);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SLOW_SEGMENT: slow_segment_q <= pwdata[SEG_WIDTH-1:0];
        REG_LEVEL_BEFORE: level_before_q <= pwdata[LEVEL_WIDTH-1:0];
        REG_LEVEL_AT:     level_at_q     <= pwdata[LEVEL_WIDTH-1:0];
        REG_LEVEL_TOP:    level_top_q    <= pwdata[LEVEL_WIDTH-1:0];
        default:          slow_segment_q <= slow_segment_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_SLOW_SEGMENT: prdata = APB_DATA_WIDTH'(slow_segment_q);
      REG_LEVEL_BEFORE: prdata = APB_DATA_WIDTH'(level_before_q);
      REG_LEVEL_AT:     prdata = APB_DATA_WIDTH'(level_at_q);
      REG_LEVEL_TOP:    prdata = APB_DATA_WIDTH'(level_top_q);
      default:          prdata = '0;
    endcase
  end

  assign slow_segment_o = slow_segment_q;
  assign level_before_o = level_before_q;
  assign level_at_o     = level_at_q;
  assign level_top_o    = level_top_q;

  // Check that a write to the slow segment lands in the register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && reg_idx == REG_SLOW_SEGMENT) |=> slow_segment_q == $past(pwdata[SEG_WIDTH-1:0]))
    else $error("slow segment write lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && reg_idx == REG_LEVEL_TOP) |=> level_top_q == $past(pwdata[LEVEL_WIDTH-1:0]))
    else $error("top level write lost");

endmodule

FILE: rtl/dtpm_front.sv
// Segment decode, operand select and multiply stages.
module dtpm_front #(
  parameter int LEVEL_WIDTH = 10
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  logic [dtpm_pkg::DMX_WIDTH-1:0]          dmx_value_i,
  input  logic [dtpm_pkg::SEG_WIDTH-1:0]          slow_segment_i,
  input  logic [LEVEL_WIDTH-1:0]                  level_before_i,
  input  logic [LEVEL_WIDTH-1:0]                  level_at_i,
  input  logic [LEVEL_WIDTH-1:0]                  level_top_i,
  output logic                                    valid_o,
  output logic [LEVEL_WIDTH+dtpm_pkg::DMX_WIDTH-1:0] product_o,
  output logic [dtpm_pkg::DIVISOR_WIDTH-1:0]      divisor_o,
  output logic [LEVEL_WIDTH-1:0]                  base_o
);
  import dtpm_pkg::*;

  localparam int NUM_WIDTH = LEVEL_WIDTH + DMX_WIDTH;

  logic [SEG_WIDTH-1:0]     seg;
  logic [SEG_WIDTH-1:0]     slow;
  logic [LEVEL_WIDTH-1:0]   rise_slow;
  logic [LEVEL_WIDTH-1:0]   rise_top;

  logic [LEVEL_WIDTH-1:0]   mul_a_d, mul_a_q;
  logic [DMX_WIDTH-1:0]     mul_b_d, mul_b_q;
  logic [DIVISOR_WIDTH-1:0] div_d, div_q;
  logic [LEVEL_WIDTH-1:0]   base_d, base_q;
  logic                     op_valid_q;

  logic [NUM_WIDTH-1:0]     product_q;
  logic [DIVISOR_WIDTH-1:0] div_p_q;
  logic [LEVEL_WIDTH-1:0]   base_p_q;
  logic                     prod_valid_q;

  assign seg       = dmx_value_i[DMX_WIDTH-1:DMX_WIDTH-SEG_WIDTH];
  assign slow      = (slow_segment_i == '0) ? SEG_WIDTH'(1) : slow_segment_i;
  assign rise_slow = (level_at_i > level_before_i) ? level_at_i - level_before_i : '0;
  assign rise_top  = (level_top_i > level_at_i) ? level_top_i - level_at_i : '0;

  // Pick the piece: numerator factors, divisor and starting level
  always_comb begin
    if (seg < slow) begin
      mul_a_d = level_before_i;
      mul_b_d = dmx_value_i;
      div_d   = {slow, 4'h0} - 8'd1;
      base_d  = '0;
    end else if (seg == slow) begin
      mul_a_d = rise_slow;
      mul_b_d = {4'h0, dmx_value_i[3:0]} + 8'd1;
      div_d   = SEG_SPAN;
      base_d  = level_before_i;
    end else begin
      mul_a_d = rise_top;
      mul_b_d = dmx_value_i - {slow, 4'hF};
      div_d   = {4'hF - slow, 4'h0};
      base_d  = level_at_i;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      op_valid_q   <= valid_i;
      prod_valid_q <= op_valid_q;
    end
  end

  // Register operands, then the product
  always_ff @(posedge clk_i) begin
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    div_q     <= div_d;
    base_q    <= base_d;
    product_q <= NUM_WIDTH'(mul_a_q) * NUM_WIDTH'(mul_b_q);
    div_p_q   <= div_q;
    base_p_q  <= base_q;
  end

  assign valid_o   = prod_valid_q;
  assign product_o = product_q;
  assign divisor_o = div_p_q;
  assign base_o    = base_p_q;

  // The divider needs a nonzero divisor and a quotient that fits the level width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_q |-> div_q != '0)
    else $error("zero divisor entered the pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_valid_q |-> mul_b_q <= div_q)
    else $error("step count exceeds piece span");

endmodule

FILE: rtl/dtpm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module dtpm_div #(
  parameter int LEVEL_WIDTH = 10
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic [LEVEL_WIDTH+dtpm_pkg::DMX_WIDTH-1:0] numer_i,
  input  logic [dtpm_pkg::DIVISOR_WIDTH-1:0]         divisor_i,
  input  logic [LEVEL_WIDTH-1:0]                     base_i,
  output logic                                       valid_o,
  output logic [LEVEL_WIDTH-1:0]                     quotient_o,
  output logic [LEVEL_WIDTH-1:0]                     base_o
);
  import dtpm_pkg::*;

  localparam int NUM_WIDTH = LEVEL_WIDTH + DMX_WIDTH;

  logic [NUM_WIDTH-1:0]     rem_q  [LEVEL_WIDTH];
  logic [LEVEL_WIDTH-1:0]   quo_q  [LEVEL_WIDTH];
  logic [DIVISOR_WIDTH-1:0] div_q  [LEVEL_WIDTH];
  logic [LEVEL_WIDTH-1:0]   base_q [LEVEL_WIDTH];
  logic [LEVEL_WIDTH-1:0]   valid_q;

  for (genvar k = 0; k < LEVEL_WIDTH; k++) begin : g_stage
    localparam int BIT = LEVEL_WIDTH - 1 - k;

    logic [NUM_WIDTH-1:0]     rem_in;
    logic [LEVEL_WIDTH-1:0]   quo_in;
    logic [DIVISOR_WIDTH-1:0] div_in;
    logic [LEVEL_WIDTH-1:0]   base_in;
    logic                     valid_in;
    logic [NUM_WIDTH-1:0]     trial;
    logic                     fits;

    if (k == 0) begin : g_first
      assign rem_in   = numer_i;
      assign quo_in   = '0;
      assign div_in   = divisor_i;
      assign base_in  = base_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign rem_in   = rem_q[k-1];
      assign quo_in   = quo_q[k-1];
      assign div_in   = div_q[k-1];
      assign base_in  = base_q[k-1];
      assign valid_in = valid_q[k-1];
    end

    // Try the shifted divisor against the partial remainder
    assign trial = NUM_WIDTH'(div_in) << BIT;
    assign fits  = rem_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= fits ? rem_in - trial : rem_in;
      quo_q[k]  <= quo_in | (LEVEL_WIDTH'(fits) << BIT);
      div_q[k]  <= div_in;
      base_q[k] <= base_in;
    end
  end

  assign valid_o    = valid_q[LEVEL_WIDTH-1];
  assign quotient_o = quo_q[LEVEL_WIDTH-1];
  assign base_o     = base_q[LEVEL_WIDTH-1];

  // A finished division leaves a remainder below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LEVEL_WIDTH-1] |-> rem_q[LEVEL_WIDTH-1] < NUM_WIDTH'(div_q[LEVEL_WIDTH-1]))
    else $error("division did not converge");

endmodule
